// File: design/nprs_pkg.sv
`timescale 1ns / 1ps
package nprs_pkg;

  localparam int unsigned MODE_W = 2;
  localparam int unsigned ADDR_W = 32;
  localparam int unsigned OP_W   = 3;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned POS_W  = 3;

  localparam int unsigned PAGE_BYTES_DEF = 2048;

  localparam logic [MODE_W-1:0] MODE_REQ    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_STATUS = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DATA   = 2'd2;

  localparam logic [OP_W-1:0] OP_SELECT   = 3'd0;
  localparam logic [OP_W-1:0] OP_CMD      = 3'd1;
  localparam logic [OP_W-1:0] OP_ADDR     = 3'd2;
  localparam logic [OP_W-1:0] OP_DATA     = 3'd3;
  localparam logic [OP_W-1:0] OP_DESELECT = 3'd4;
  localparam logic [OP_W-1:0] OP_ERROR    = 3'd5;

  localparam logic [BYTE_W-1:0] CMD_READ    = 8'h00;
  localparam logic [BYTE_W-1:0] CMD_CONFIRM = 8'h30;

  // position of each result inside an emitted sequence
  localparam logic [POS_W-1:0] POS_HEAD      = 3'd0;
  localparam logic [POS_W-1:0] POS_DESEL     = 3'd1;
  localparam logic [POS_W-1:0] POS_CMD_READ  = 3'd1;
  localparam logic [POS_W-1:0] POS_COL_LO    = 3'd2;
  localparam logic [POS_W-1:0] POS_COL_HI    = 3'd3;
  localparam logic [POS_W-1:0] POS_PAGE_0    = 3'd4;
  localparam logic [POS_W-1:0] POS_PAGE_1    = 3'd5;
  localparam logic [POS_W-1:0] POS_PAGE_2    = 3'd6;
  localparam logic [POS_W-1:0] POS_CMD_CONF  = 3'd7;

  typedef enum logic [1:0] {
    TAIL_NONE,
    TAIL_DESEL,
    TAIL_BURST
  } tail_e;

  // results caused by one accepted transaction: a head result and a tail
  typedef struct packed {
    logic [OP_W-1:0]   head_op;
    logic [BYTE_W-1:0] head_val;
    logic [ADDR_W-1:0] head_idx;
    tail_e             tail;
    logic [ADDR_W-1:0] addr;
  } desc_t;

endpackage

// File: design/nprs_if.sv
`timescale 1ns / 1ps
interface nprs_in_if;
  logic                           valid;
  logic                           ready;
  logic [nprs_pkg::MODE_W-1:0]    mode;
  logic [nprs_pkg::ADDR_W-1:0]    start_address;
  logic [nprs_pkg::ADDR_W-1:0]    byte_count;
  logic                           ready_flag;
  logic [nprs_pkg::BYTE_W-1:0]    flash_byte;

  modport source (output valid, mode, start_address, byte_count, ready_flag, flash_byte,
                  input ready);
  modport sink   (input valid, mode, start_address, byte_count, ready_flag, flash_byte,
                  output ready);
endinterface

interface nprs_out_if;
  logic                        valid;
  logic                        ready;
  logic [nprs_pkg::OP_W-1:0]   operation;
  logic [nprs_pkg::BYTE_W-1:0] byte_value;
  logic [nprs_pkg::ADDR_W-1:0] buffer_index;
  logic                        last;

  modport source (output valid, operation, byte_value, buffer_index, last, input ready);
  modport sink   (input valid, operation, byte_value, buffer_index, last, output ready);
endinterface

// File: design/nprs_ctrl.sv
`timescale 1ns / 1ps
module nprs_ctrl #(
  parameter int unsigned PAGE_BYTES = nprs_pkg::PAGE_BYTES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  nprs_in_if.sink          in_i,
  input  logic             free_i,
  output logic             load_o,
  output nprs_pkg::desc_t  desc_o
);
  import nprs_pkg::*;

  localparam int unsigned COL_W = $clog2(PAGE_BYTES);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_WAIT = 2'd1;
  localparam logic [1:0] PH_DATA = 2'd2;

  logic [1:0]        phase_q, phase_d;
  logic [ADDR_W-1:0] cur_q, cur_d;
  logic [ADDR_W-1:0] done_q, done_d;
  logic [ADDR_W-1:0] total_q, total_d;
  logic [ADDR_W-1:0] cur_inc, done_inc;
  logic              accept;
  logic              has_res;

  assign in_i.ready = free_i;
  assign accept     = in_i.valid && free_i;
  assign cur_inc    = cur_q + 32'd1;
  assign done_inc   = done_q + 32'd1;
  assign load_o     = accept && has_res;

  always_comb begin
    phase_d         = phase_q;
    cur_d           = cur_q;
    done_d          = done_q;
    total_d         = total_q;
    has_res         = 1'b1;
    desc_o.head_op  = OP_ERROR;
    desc_o.head_val = '0;
    desc_o.head_idx = '0;
    desc_o.tail     = TAIL_NONE;
    desc_o.addr     = in_i.start_address;
    if (in_i.mode == MODE_REQ && phase_q == PH_IDLE) begin
      desc_o.head_op = OP_SELECT;
      if (in_i.byte_count == '0) begin
        desc_o.tail = TAIL_DESEL;
      end else begin
        desc_o.tail = TAIL_BURST;
        cur_d       = in_i.start_address;
        done_d      = '0;
        total_d     = in_i.byte_count;
        phase_d     = PH_WAIT;
      end
    end else if (in_i.mode == MODE_STATUS && phase_q == PH_WAIT) begin
      has_res = 1'b0;
      if (in_i.ready_flag) begin
        phase_d = PH_DATA;
      end
    end else if (in_i.mode == MODE_DATA && phase_q == PH_DATA) begin
      desc_o.head_op  = OP_DATA;
      desc_o.head_val = in_i.flash_byte;
      desc_o.head_idx = done_q;
      desc_o.addr     = cur_inc;
      done_d          = done_inc;
      cur_d           = cur_inc;
      if (done_inc == total_q) begin
        desc_o.tail = TAIL_DESEL;
        phase_d     = PH_IDLE;
      end else if (cur_inc[COL_W-1:0] == '0) begin
        desc_o.tail = TAIL_BURST;
        phase_d     = PH_WAIT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cur_q   <= '0;
      done_q  <= '0;
      total_q <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      cur_q   <= cur_d;
      done_q  <= done_d;
      total_q <= total_d;
    end
  end

endmodule

// File: design/nprs_emit.sv
`timescale 1ns / 1ps
module nprs_emit #(
  parameter int unsigned PAGE_BYTES = nprs_pkg::PAGE_BYTES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  nprs_pkg::desc_t  desc_i,
  output logic             free_o,
  nprs_out_if.source       out_o
);
  import nprs_pkg::*;

  localparam int unsigned COL_W = $clog2(PAGE_BYTES);

  logic              busy_q, busy_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  desc_t             desc_q;
  logic [POS_W-1:0]  last_pos;
  logic              at_last;
  logic [ADDR_W-1:0] col;
  logic [ADDR_W-1:0] page;
  logic [BYTE_W-1:0] burst_val;
  logic [OP_W-1:0]   burst_op;

  assign col  = desc_q.addr & ADDR_W'(PAGE_BYTES - 1);
  assign page = desc_q.addr >> COL_W;

  always_comb begin
    case (desc_q.tail)
      TAIL_DESEL: last_pos = POS_DESEL;
      TAIL_BURST: last_pos = POS_CMD_CONF;
      default:    last_pos = POS_HEAD;
    endcase
  end

  always_comb begin
    burst_op = OP_ADDR;
    case (pos_q)
      POS_CMD_READ: begin
        burst_op  = OP_CMD;
        burst_val = CMD_READ;
      end
      POS_COL_LO:   burst_val = col[7:0];
      POS_COL_HI:   burst_val = col[15:8];
      POS_PAGE_0:   burst_val = page[7:0];
      POS_PAGE_1:   burst_val = page[15:8];
      POS_PAGE_2:   burst_val = page[23:16];
      POS_CMD_CONF: begin
        burst_op  = OP_CMD;
        burst_val = CMD_CONFIRM;
      end
      default:      burst_val = '0;
    endcase
  end

  always_comb begin
    out_o.valid        = busy_q;
    out_o.last         = at_last;
    out_o.operation    = desc_q.head_op;
    out_o.byte_value   = desc_q.head_val;
    out_o.buffer_index = desc_q.head_idx;
    if (pos_q != POS_HEAD) begin
      out_o.buffer_index = '0;
      if (desc_q.tail == TAIL_BURST) begin
        out_o.operation  = burst_op;
        out_o.byte_value = burst_val;
      end else begin
        out_o.operation  = OP_DESELECT;
        out_o.byte_value = '0;
      end
    end
  end

  assign at_last = (pos_q == last_pos);
  assign free_o  = !busy_q || (out_o.ready && at_last);

  always_comb begin
    busy_d = busy_q;
    pos_d  = pos_q;
    if (busy_q && out_o.ready) begin
      if (at_last) begin
        busy_d = 1'b0;
      end else begin
        pos_d = pos_q + 3'd1;
      end
    end
    if (load_i) begin
      busy_d = 1'b1;
      pos_d  = POS_HEAD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pos_q  <= POS_HEAD;
    end else begin
      busy_q <= busy_d;
      pos_q  <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      desc_q <= desc_i;
    end
  end

endmodule

// File: design/nand_page_read_sequencer_unit.sv
`timescale 1ns / 1ps
// Latency: the first result of an accepted transaction is offered the cycle after acceptance.
// Throughput: one transaction per cycle while each gives a single result (data bytes
//   within a page) and out_o.ready is high; one giving n results holds the result register
//   until its last is taken (8 for a page burst, 2 for select/deselect); a status gives none.
// Reset: asynchronous, active low; phase to idle, address and counters to zero.
module nand_page_read_sequencer_unit #(
  parameter int unsigned PAGE_BYTES = nprs_pkg::PAGE_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  nprs_in_if.sink     in_i,
  nprs_out_if.source  out_o
);
  import nprs_pkg::*;

  logic  free;
  logic  load;
  desc_t desc;

  nprs_ctrl #(
    .PAGE_BYTES (PAGE_BYTES)
  ) u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .free_i (free),
    .load_o (load),
    .desc_o (desc)
  );

  nprs_emit #(
    .PAGE_BYTES (PAGE_BYTES)
  ) u_emit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (load),
    .desc_i (desc),
    .free_o (free),
    .out_o  (out_o)
  );

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> free)
    else $error("result sequence loaded while emitter busy");

  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && out_o.last && !load) |=> !out_o.valid)
    else $error("result offered without a transaction");

  a_index_only_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.operation != OP_DATA) |-> out_o.buffer_index == '0)
    else $error("buffer index set on a non-data result");

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
module tb;
  import nprs_pkg::*;

  localparam int unsigned PAGE_BYTES     = PAGE_BYTES_DEF;
  localparam int unsigned ITEMS_PER_STEP = 46;
  localparam int unsigned CYCLE_LIMIT    = 200000;
  localparam int unsigned SETTLE_CYCLES  = 20;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    RD_IDLE,
    RD_WAIT,
    RD_DATA
  } rd_phase_e;

  typedef enum logic [1:0] {
    EXP_PREDICTED,
    EXP_ERROR,
    EXP_SELECT_DESELECT,
    EXP_NOTHING
  } exp_kind_e;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [ADDR_W-1:0] start_address;
    logic [ADDR_W-1:0] byte_count;
    logic              ready_flag;
    logic [BYTE_W-1:0] flash_byte;
  } rd_item_t;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [BYTE_W-1:0] byte_value;
    logic [ADDR_W-1:0] buffer_index;
    logic              last;
  } rd_result_t;

  typedef struct {
    rd_item_t  item;
    exp_kind_e kind;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  nprs_in_if  in_if ();
  nprs_out_if out_if ();

  nand_page_read_sequencer_unit #(
    .PAGE_BYTES(PAGE_BYTES)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  rd_phase_e         rd_phase;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] rd_done;
  logic [ADDR_W-1:0] rd_total;

  rd_result_t  new_ops[$];
  rd_result_t  pending_ops[$];
  stim_row_t   opening_rows[$];
  stim_row_t   closing_rows[$];

  int unsigned src_idle_pct;
  int unsigned snk_stall_pct;
  int unsigned mismatches = 0;
  int unsigned cycle_cnt = 0;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    cycle_cnt = cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  function automatic void add_op(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] val,
                                 input logic [ADDR_W-1:0] idx, input logic lst);
    rd_result_t r;
    r.operation    = op;
    r.byte_value   = val;
    r.buffer_index = idx;
    r.last         = lst;
    new_ops.push_back(r);
  endfunction

  function automatic void add_read_burst(input logic [ADDR_W-1:0] addr);
    logic [ADDR_W-1:0] col;
    logic [ADDR_W-1:0] pg;
    col = addr % PAGE_BYTES;
    pg  = addr / PAGE_BYTES;
    add_op(OP_CMD, CMD_READ, '0, 1'b0);
    add_op(OP_ADDR, col[7:0], '0, 1'b0);
    add_op(OP_ADDR, col[15:8], '0, 1'b0);
    add_op(OP_ADDR, pg[7:0], '0, 1'b0);
    add_op(OP_ADDR, pg[15:8], '0, 1'b0);
    add_op(OP_ADDR, pg[23:16], '0, 1'b0);
    add_op(OP_CMD, CMD_CONFIRM, '0, 1'b0);
  endfunction

  // next state and the operations caused by one transaction
  function automatic void nand_read_step(input rd_item_t it);
    new_ops.delete();
    if (it.mode == MODE_REQ && rd_phase == RD_IDLE) begin
      add_op(OP_SELECT, '0, '0, 1'b0);
      if (it.byte_count == '0) begin
        add_op(OP_DESELECT, '0, '0, 1'b0);
      end else begin
        rd_addr  = it.start_address;
        rd_done  = '0;
        rd_total = it.byte_count;
        add_read_burst(it.start_address);
        rd_phase = RD_WAIT;
      end
    end else if (it.mode == MODE_STATUS && rd_phase == RD_WAIT) begin
      if (it.ready_flag) begin
        rd_phase = RD_DATA;
      end
    end else if (it.mode == MODE_DATA && rd_phase == RD_DATA) begin
      add_op(OP_DATA, it.flash_byte, rd_done, 1'b0);
      rd_done = rd_done + 1;
      rd_addr = rd_addr + 1;
      if (rd_done == rd_total) begin
        add_op(OP_DESELECT, '0, '0, 1'b0);
        rd_phase = RD_IDLE;
      end else if (rd_addr % PAGE_BYTES == 0) begin
        add_read_burst(rd_addr);
        rd_phase = RD_WAIT;
      end
    end else begin
      add_op(OP_ERROR, '0, '0, 1'b0);
    end
    if (new_ops.size() != 0) begin
      new_ops[new_ops.size()-1].last = 1'b1;
    end
  endfunction

  function automatic stim_row_t stim_row(input logic [MODE_W-1:0] m, input logic [ADDR_W-1:0] a,
                                         input logic [ADDR_W-1:0] n, input logic f,
                                         input logic [BYTE_W-1:0] b, input exp_kind_e k);
    stim_row_t r;
    r.item.mode          = m;
    r.item.start_address = a;
    r.item.byte_count    = n;
    r.item.ready_flag    = f;
    r.item.flash_byte    = b;
    r.kind               = k;
    return r;
  endfunction

  // mostly well-formed read sequences, with some out-of-phase noise
  function automatic rd_item_t pick_item();
    rd_item_t it;
    it.mode          = MODE_UNUSED;
    it.start_address = $urandom;
    it.byte_count    = $urandom_range(40);
    it.ready_flag    = 1'($urandom_range(1));
    it.flash_byte    = BYTE_W'($urandom_range(255));
    if ($urandom_range(99) < 8) begin
      it.mode = MODE_W'($urandom_range(3));
      return it;
    end
    case (rd_phase)
      RD_IDLE: begin
        it.mode = MODE_REQ;
        if ($urandom_range(9) == 0) begin
          it.byte_count = '0;
        end else if ($urandom_range(9) == 0) begin
          it.byte_count = $urandom_range(40, 1);
        end else begin
          it.byte_count = $urandom_range(12, 1);
        end
        if ($urandom_range(19) == 0) begin
          it.start_address = 32'hffff_ffff - $urandom_range(6);
        end else if ($urandom_range(3) != 0) begin
          it.start_address = it.start_address - (it.start_address % PAGE_BYTES)
                             + PAGE_BYTES - $urandom_range(8, 1);
        end
      end
      RD_WAIT: begin
        it.mode       = MODE_STATUS;
        it.ready_flag = ($urandom_range(99) < 70);
      end
      default: begin
        it.mode = MODE_DATA;
      end
    endcase
    return it;
  endfunction

  task automatic send_item(input rd_item_t it, input exp_kind_e kind);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.mode          <= it.mode;
    in_if.start_address <= it.start_address;
    in_if.byte_count    <= it.byte_count;
    in_if.ready_flag    <= it.ready_flag;
    in_if.flash_byte    <= it.flash_byte;
    do @(posedge clk_i); while (!in_if.ready);
    nand_read_step(it);
    case (kind)
      EXP_ERROR: begin
        new_ops.delete();
        add_op(OP_ERROR, '0, '0, 1'b1);
      end
      EXP_SELECT_DESELECT: begin
        new_ops.delete();
        add_op(OP_SELECT, '0, '0, 1'b0);
        add_op(OP_DESELECT, '0, '0, 1'b1);
      end
      EXP_NOTHING: begin
        new_ops.delete();
      end
      default: begin
      end
    endcase
    foreach (new_ops[i]) pending_ops.push_back(new_ops[i]);
  endtask

  task automatic walk_rows(input stim_row_t rows[$]);
    foreach (rows[i]) send_item(rows[i].item, rows[i].kind);
  endtask

  task automatic drain_pending();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (pending_ops.size() != 0) @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin : check_results
    rd_result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_ops.size() == 0) begin
        $error("unexpected transaction: operation %0d byte_value %0h", out_if.operation,
               out_if.byte_value);
        mismatches = mismatches + 1;
      end else begin
        want = pending_ops.pop_front();
        if (out_if.operation !== want.operation) begin
          $error("operation: expected %0d, got %0d", want.operation, out_if.operation);
          mismatches = mismatches + 1;
        end
        if (out_if.byte_value !== want.byte_value) begin
          $error("byte_value: expected %0h, got %0h", want.byte_value, out_if.byte_value);
          mismatches = mismatches + 1;
        end
        if (out_if.buffer_index !== want.buffer_index) begin
          $error("buffer_index: expected %0d, got %0d", want.buffer_index,
                 out_if.buffer_index);
          mismatches = mismatches + 1;
        end
        if (out_if.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_if.last);
          mismatches = mismatches + 1;
        end
      end
    end
  end

  initial begin
    rst_ni               = 1'b0;
    in_if.valid          = 1'b0;
    in_if.mode           = MODE_REQ;
    in_if.start_address  = '0;
    in_if.byte_count     = '0;
    in_if.ready_flag     = 1'b0;
    in_if.flash_byte     = '0;
    src_idle_pct         = 0;
    snk_stall_pct        = 0;
    rd_phase             = RD_IDLE;
    rd_addr              = '0;
    rd_done              = '0;
    rd_total             = '0;

    opening_rows.push_back(stim_row(MODE_STATUS, '0, '0, 1'b1, 8'h00, EXP_ERROR));
    opening_rows.push_back(stim_row(MODE_DATA, '0, '0, 1'b0, 8'hff, EXP_ERROR));
    opening_rows.push_back(stim_row(MODE_UNUSED, '1, '1, 1'b1, 8'hff, EXP_ERROR));
    opening_rows.push_back(stim_row(MODE_REQ, '1, '0, 1'b0, 8'h00, EXP_SELECT_DESELECT));
    opening_rows.push_back(stim_row(MODE_REQ, 32'hffff_fffe, 32'd3, 1'b0, 8'h00,
                                    EXP_PREDICTED));
    opening_rows.push_back(stim_row(MODE_REQ, '0, '0, 1'b1, 8'h00, EXP_ERROR));
    opening_rows.push_back(stim_row(MODE_DATA, '1, '1, 1'b0, 8'h00, EXP_ERROR));
    opening_rows.push_back(stim_row(MODE_STATUS, '1, '1, 1'b0, 8'hff, EXP_NOTHING));
    opening_rows.push_back(stim_row(MODE_STATUS, '0, '0, 1'b1, 8'h00, EXP_NOTHING));
    opening_rows.push_back(stim_row(MODE_STATUS, '0, '0, 1'b1, 8'h00, EXP_ERROR));
    opening_rows.push_back(stim_row(MODE_REQ, 32'h0000_1000, 32'd4, 1'b0, 8'h00, EXP_ERROR));
    opening_rows.push_back(stim_row(MODE_DATA, '0, '0, 1'b0, 8'h00, EXP_PREDICTED));
    opening_rows.push_back(stim_row(MODE_DATA, '1, '1, 1'b1, 8'hff, EXP_PREDICTED));
    opening_rows.push_back(stim_row(MODE_STATUS, '0, '0, 1'b1, 8'h00, EXP_NOTHING));
    opening_rows.push_back(stim_row(MODE_DATA, '0, '0, 1'b0, 8'h5a, EXP_PREDICTED));
    // read ending exactly on a page boundary: deselect, no new burst
    opening_rows.push_back(stim_row(MODE_REQ, 32'h0000_07fe, 32'd2, 1'b0, 8'h00,
                                    EXP_PREDICTED));
    opening_rows.push_back(stim_row(MODE_STATUS, '0, '0, 1'b1, 8'h00, EXP_NOTHING));
    opening_rows.push_back(stim_row(MODE_DATA, '0, '0, 1'b0, 8'h81, EXP_PREDICTED));
    opening_rows.push_back(stim_row(MODE_DATA, '0, '0, 1'b0, 8'h7e, EXP_PREDICTED));
    opening_rows.push_back(stim_row(MODE_UNUSED, '0, '0, 1'b0, 8'h00, EXP_ERROR));

    // longest request, left running at the end
    closing_rows.push_back(stim_row(MODE_REQ, 32'h0000_07ff, '1, 1'b1, 8'h00, EXP_PREDICTED));
    closing_rows.push_back(stim_row(MODE_STATUS, '0, '0, 1'b1, 8'h00, EXP_NOTHING));
    closing_rows.push_back(stim_row(MODE_DATA, '0, '0, 1'b0, 8'hc3, EXP_PREDICTED));
    closing_rows.push_back(stim_row(MODE_STATUS, '0, '0, 1'b1, 8'h00, EXP_NOTHING));
    closing_rows.push_back(stim_row(MODE_DATA, '0, '0, 1'b0, 8'h3c, EXP_PREDICTED));

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    walk_rows(opening_rows);

    for (int unsigned step = 0; step < 4; step++) begin
      drain_pending();
      case (step)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 71; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 71; end
        default: begin src_idle_pct = 11; snk_stall_pct = 11; end
      endcase
      repeat (ITEMS_PER_STEP) send_item(pick_item(), EXP_PREDICTED);
    end
    while (rd_phase != RD_IDLE) send_item(pick_item(), EXP_PREDICTED);

    walk_rows(closing_rows);

    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (pending_ops.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: nand_page_read_sequencer_unit.f
design/nprs_pkg.sv
design/nprs_if.sv
design/nprs_ctrl.sv
design/nprs_emit.sv
design/nand_page_read_sequencer_unit.sv
dv/tb.sv
